[rtl/core/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg: shared definitions for the line field selector
// Request types, register indexes, byte codes and a small helper function.
// ----------------------------------------------------------------------------
package lfs_pkg;

  // Default sizes of the line buffer and of the pattern matcher.
  localparam int unsigned LINE_MAX_DEF    = 64;
  localparam int unsigned PATTERN_MAX_DEF = 16;

  // Byte codes with a fixed meaning.
  localparam logic [7:0] NL_BYTE  = 8'd10;
  localparam logic [7:0] TAB_BYTE = 8'd9;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_NUMBER   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd4;

  // Reset value of the separator register (space).
  localparam logic [7:0] SEPARATOR_RST = 8'd32;

  // Input request: one stream byte or the end of the stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_req_t;

  // Output request: one byte of a line's output run.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_done;
  } out_req_t;

  // Per-cycle control handed from the sequencer to a worker unit.
  typedef struct packed {
    logic clear;
    logic step;
  } step_ctrl_t;

  // Line processing sequencer.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // Tab always separates; the separator byte does too unless it is zero.
  function automatic logic is_sep(logic [7:0] b, logic [7:0] sep);
    return (b == TAB_BYTE) || ((sep != 8'd0) && (b == sep));
  endfunction

endpackage

[rtl/core/line_field_selector_with_filter_core.sv]
// ----------------------------------------------------------------------------
// line_field_selector_with_filter_core: line field selector with filter
// Buffers a text line, checks it for a pattern with a chain of match cells
// and then sends out the whole line or one field, closed by a newline.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid_i/in_stall_o    in_req_i  (lfs_pkg::in_req_t)
//   out      output     out_valid_o/out_stall_i  out_req_o (lfs_pkg::out_req_t)
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// Bytes inside a line are taken while the core is idle. At the end of a line
// the line buffer is read once per cycle in a match pass through the cell
// chain and, if the line passes the filter, in an output pass that pauses
// while the output side stalls. The line buffer has a single read port. Input
// requests are stalled during both passes. Reset clears all control state at
// once; the line buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module line_field_selector_with_filter_core #(
  parameter int unsigned LINE_MAX    = lfs_pkg::LINE_MAX_DEF,
  parameter int unsigned PATTERN_MAX = lfs_pkg::PATTERN_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lfs_pkg::in_req_t                    in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lfs_pkg::out_req_t                   out_req_o,
  input  logic                                cfg_we_i,
  input  logic [lfs_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned LenW = $clog2(LINE_MAX);
  localparam int unsigned PmW  = $clog2(PATTERN_MAX + 1);
  localparam logic [LenW-1:0] LenCap = LenW'(LINE_MAX - 1);

  // Configuration registers.
  logic [7:0]   cfg_sep_q;
  logic [7:0]   cfg_field_q;
  logic [4:0]   cfg_plen_q;
  logic [127:0] cfg_pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sep_q   <= lfs_pkg::SEPARATOR_RST;
      cfg_field_q <= 8'd0;
      cfg_plen_q  <= 5'd0;
      cfg_pat_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lfs_pkg::CFG_SEPARATOR:      cfg_sep_q          <= cfg_data_i[7:0];
        lfs_pkg::CFG_FIELD_NUMBER:   cfg_field_q        <= cfg_data_i[7:0];
        lfs_pkg::CFG_PATTERN_LENGTH: cfg_plen_q         <= cfg_data_i[4:0];
        lfs_pkg::CFG_PATTERN_LOW:    cfg_pat_q[63:0]    <= cfg_data_i;
        lfs_pkg::CFG_PATTERN_HIGH:   cfg_pat_q[127:64]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pattern bytes and the effective pattern length.
  logic [7:0]     pat_byte [PATTERN_MAX];
  logic [PmW-1:0] pat_lim;
  logic [PmW-1:0] pat_eff;
  logic           zero_found;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    assign pat_byte[k] = cfg_pat_q[8*k +: 8];
  end

  // The pattern stops at its first zero byte and at the matcher length.
  always_comb begin
    if (cfg_plen_q > 5'(PATTERN_MAX)) begin
      pat_lim = PmW'(PATTERN_MAX);
    end else begin
      pat_lim = PmW'(cfg_plen_q);
    end
    pat_eff    = pat_lim;
    zero_found = 1'b0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (!zero_found && (PmW'(k) < pat_lim) && (pat_byte[k] == 8'd0)) begin
        pat_eff    = PmW'(k);
        zero_found = 1'b1;
      end
    end
  end

  // Sequencer and line state.
  lfs_pkg::state_e   state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   kept_q, kept_d;
  logic              zero_q, zero_d;
  logic [LenW-1:0]   rd_addr_q, rd_addr_d;
  logic              rv_q, rv_d;
  logic [7:0]        rdata_q;
  logic              matched_q, matched_d;
  logic              ov_q, ov_d;
  lfs_pkg::out_req_t out_q, out_d;

  logic              in_acc;
  logic              wr_en;
  logic              rd_en;
  logic              slot_free;
  logic              consume;
  logic              hit;
  logic              sel;
  lfs_pkg::step_ctrl_t cell_ctrl;
  lfs_pkg::step_ctrl_t sel_ctrl;

  logic [7:0] line_mem [LINE_MAX];

  assign in_stall_o = (state_q != lfs_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !ov_q || !out_stall_i;

  // Match cell chain; each cell takes the flag of its left neighbor.
  logic [PATTERN_MAX-1:0] flag;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_next
      assign prev = flag[k-1];
    end
    lfs_match_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .line_byte_i (rdata_q),
      .pat_byte_i  (pat_byte[k]),
      .prev_flag_i (prev),
      .flag_o      (flag[k])
    );
  end

  // A full match shows up in the cell at the end of the effective pattern.
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (flag[k] && (pat_eff == PmW'(k + 1))) begin
        hit = 1'b1;
      end
    end
  end

  // Field tokenizer for the output pass.
  lfs_field_sel u_field_sel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (sel_ctrl),
    .line_byte_i    (rdata_q),
    .separator_i    (cfg_sep_q),
    .field_number_i (cfg_field_q),
    .sel_o          (sel)
  );

  // Line sequencer: collect, match pass, output pass.
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    kept_d    = kept_q;
    zero_d    = zero_q;
    rd_addr_d = rd_addr_q;
    rv_d      = rv_q;
    matched_d = matched_q;
    ov_d      = ov_q;
    out_d     = out_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    consume   = 1'b0;
    cell_ctrl = '0;
    sel_ctrl  = '0;

    // The pending output request leaves when the far side takes it.
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      lfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.end_of_stream) begin
            if (len_q != '0) begin
              state_d         = lfs_pkg::ST_SCAN;
              rd_addr_d       = '0;
              rv_d            = 1'b0;
              matched_d       = 1'b0;
              cell_ctrl.clear = 1'b1;
            end
          end else if (in_req_i.data_byte == lfs_pkg::NL_BYTE) begin
            state_d         = lfs_pkg::ST_SCAN;
            rd_addr_d       = '0;
            rv_d            = 1'b0;
            matched_d       = 1'b0;
            cell_ctrl.clear = 1'b1;
          end else if (len_q < LenCap) begin
            wr_en = 1'b1;
            len_d = len_q + 1'b1;
            if (!zero_q) begin
              if (in_req_i.data_byte == 8'd0) begin
                zero_d = 1'b1;
              end else begin
                kept_d = kept_q + 1'b1;
              end
            end
          end
        end
      end

      lfs_pkg::ST_SCAN: begin
        cell_ctrl.step = rv_q;
        matched_d      = matched_q || hit;
        rd_en          = (rd_addr_q < kept_q);
        rv_d           = rd_en;
        if (rd_en) begin
          rd_addr_d = rd_addr_q + 1'b1;
        end
        if (!rv_q && (rd_addr_q == kept_q)) begin
          if ((pat_eff == '0) || matched_q || hit) begin
            state_d        = lfs_pkg::ST_EMIT;
            rd_addr_d      = '0;
            rv_d           = 1'b0;
            sel_ctrl.clear = 1'b1;
          end else begin
            state_d   = lfs_pkg::ST_IDLE;
            rd_addr_d = '0;
            len_d     = '0;
            kept_d    = '0;
            zero_d    = 1'b0;
          end
        end
      end

      lfs_pkg::ST_EMIT: begin
        consume       = rv_q && slot_free;
        sel_ctrl.step = consume;
        rd_en         = (!rv_q || consume) && (rd_addr_q < kept_q);
        if (rd_en) begin
          rd_addr_d = rd_addr_q + 1'b1;
          rv_d      = 1'b1;
        end else if (consume) begin
          rv_d = 1'b0;
        end
        if (consume && sel) begin
          ov_d            = 1'b1;
          out_d.out_byte  = rdata_q;
          out_d.line_done = 1'b0;
        end
        // All kept bytes are through: close the run with a newline.
        if (!rv_q && (rd_addr_q == kept_q) && slot_free) begin
          ov_d            = 1'b1;
          out_d.out_byte  = lfs_pkg::NL_BYTE;
          out_d.line_done = 1'b1;
          state_d         = lfs_pkg::ST_IDLE;
          rd_addr_d       = '0;
          len_d           = '0;
          kept_d          = '0;
          zero_d          = 1'b0;
        end
      end

      default: begin
        state_d = lfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lfs_pkg::ST_IDLE;
      len_q     <= '0;
      kept_q    <= '0;
      zero_q    <= 1'b0;
      rd_addr_q <= '0;
      rv_q      <= 1'b0;
      matched_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      kept_q    <= kept_d;
      zero_q    <= zero_d;
      rd_addr_q <= rd_addr_d;
      rv_q      <= rv_d;
      matched_q <= matched_d;
      ov_q      <= ov_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Line buffer: one write port for incoming bytes, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[len_q] <= in_req_i.data_byte;
    end
    if (rd_en) begin
      rdata_q <= line_mem[rd_addr_q];
    end
  end

  assign out_valid_o = ov_q;
  assign out_req_o   = out_q;

  // The read pointer never passes the kept length of the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_addr_q <= kept_q)
    else $error("line buffer read pointer beyond kept length");

  // Kept bytes are a subset of the stored raw bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= len_q)
    else $error("kept length exceeds raw line length");

  // A data byte can only be pending while the output pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_q.line_done) |-> (state_q == lfs_pkg::ST_EMIT))
    else $error("data byte pending outside the output pass");

  // Input requests are taken only between line passes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lfs_pkg::ST_IDLE) |-> !wr_en)
    else $error("line buffer written during a line pass");

endmodule

[rtl/core/lfs_match_cell.sv]
// ----------------------------------------------------------------------------
// lfs_match_cell: one cell of the substring match chain
// Holds one flag: the pattern prefix that ends at this cell's byte matched
// up to the previous line byte. The flag moves to the next cell each step.
// ----------------------------------------------------------------------------
module lfs_match_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfs_pkg::step_ctrl_t ctrl_i,
  input  logic [7:0]          line_byte_i,
  input  logic [7:0]          pat_byte_i,
  input  logic                prev_flag_i,
  output logic                flag_o
);

  logic flag_q, flag_d;

  // A prefix grows by one byte when the neighbor's shorter prefix matched.
  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end else if (ctrl_i.step) begin
      flag_d = prev_flag_i && (line_byte_i == pat_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule

[rtl/core/lfs_field_sel.sv]
// ----------------------------------------------------------------------------
// lfs_field_sel: field tokenizer for the output pass
// Tracks field boundaries over the line bytes and flags the bytes that
// belong to the selected field, or every byte when the whole line is chosen.
// ----------------------------------------------------------------------------
module lfs_field_sel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfs_pkg::step_ctrl_t ctrl_i,
  input  logic [7:0]          line_byte_i,
  input  logic [7:0]          separator_i,
  input  logic [7:0]          field_number_i,
  output logic                sel_o
);

  logic       in_field_q, in_field_d;
  logic       cur_sel_q, cur_sel_d;
  logic [7:0] fcnt_q, fcnt_d;

  logic sep;
  logic start;
  logic cur;

  // Classify the present byte and decide whether it goes out.
  always_comb begin
    sep   = lfs_pkg::is_sep(line_byte_i, separator_i);
    start = !sep && !in_field_q;
    cur   = start ? (fcnt_q == (field_number_i - 8'd1)) : cur_sel_q;
    if (field_number_i == 8'd0) begin
      sel_o = 1'b1;
    end else begin
      sel_o = !sep && cur;
    end
  end

  // Field counter saturates; field numbers above 255 can never be chosen.
  always_comb begin
    in_field_d = in_field_q;
    cur_sel_d  = cur_sel_q;
    fcnt_d     = fcnt_q;
    if (ctrl_i.clear) begin
      in_field_d = 1'b0;
      cur_sel_d  = 1'b0;
      fcnt_d     = 8'd0;
    end else if (ctrl_i.step) begin
      in_field_d = !sep;
      cur_sel_d  = sep ? 1'b0 : cur;
      if (start && (fcnt_q != 8'hFF)) begin
        fcnt_d = fcnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_field_q <= 1'b0;
      cur_sel_q  <= 1'b0;
      fcnt_q     <= 8'd0;
    end else begin
      in_field_q <= in_field_d;
      cur_sel_q  <= cur_sel_d;
      fcnt_q     <= fcnt_d;
    end
  end

endmodule

[bench/line_field_selector_with_filter_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_field_selector_with_filter_core_test: self-checking bench
// Feeds byte streams into the line field selector, predicts every output
// byte from a behavioral copy of the line, field and filter rules, and
// compares each accepted output request against the oldest prediction.
// ----------------------------------------------------------------------------
module line_field_selector_with_filter_core_test;

  localparam int unsigned LINE_MAX    = lfs_pkg::LINE_MAX_DEF;
  localparam int unsigned PATTERN_MAX = lfs_pkg::PATTERN_MAX_DEF;
  // A line that is filtered out gives no output but keeps the core busy for
  // its match pass over the line buffer; this many cycles cover that and more.
  localparam int          SETTLE_CYCLES = 2 * LINE_MAX + 24;
  // Index that maps to no register; a write to it must change nothing.
  localparam logic [lfs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid;
  logic                            in_stall_o;
  lfs_pkg::in_req_t                in_req;
  logic                            out_valid_o;
  logic                            out_stall;
  lfs_pkg::out_req_t               out_req_o;
  logic                            cfg_we;
  logic [lfs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lfs_pkg::CFG_DATA_W-1:0]  cfg_data;

  line_field_selector_with_filter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Shadow registers and line state of the behavioral copy.
  logic [7:0]  sep_reg;
  logic [7:0]  field_reg;
  logic [4:0]  plen_reg;
  logic [63:0] pat_lo_reg;
  logic [63:0] pat_hi_reg;
  logic [7:0]  line_buf [LINE_MAX];
  int          raw_len;
  int          kept_len;
  bit          zero_in_line;

  // Output bytes still owed by the core, oldest first.
  lfs_pkg::out_req_t expected_bytes [$];
  int                mismatch_count;
  int                bytes_sent;

  // Idle control of the sender and stall controls of the receiver.
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("line_field_selector_with_filter_core_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Behavioral prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pattern_byte(int i);
    if (i < 8) return pat_lo_reg[8*i +: 8];
    return pat_hi_reg[8*(i-8) +: 8];
  endfunction

  function automatic bit is_field_sep(logic [7:0] b);
    return (b == lfs_pkg::TAB_BYTE) || ((sep_reg != 8'd0) && (b == sep_reg));
  endfunction

  // The pattern is cut at PATTERN_MAX and at its first zero byte.
  function automatic int active_pattern_len();
    int n;
    n = (plen_reg > PATTERN_MAX) ? PATTERN_MAX : int'(plen_reg);
    for (int i = 0; i < n; i++) begin
      if (pattern_byte(i) == 8'd0) return i;
    end
    return n;
  endfunction

  function automatic bit line_passes_filter();
    int  n;
    bit  hit;
    n = active_pattern_len();
    if (n == 0) return 1'b1;
    if (n > kept_len) return 1'b0;
    for (int s = 0; s + n <= kept_len; s++) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (line_buf[s+k] != pattern_byte(k)) hit = 1'b0;
      end
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void owe_byte(logic [7:0] b, logic done);
    lfs_pkg::out_req_t r;
    r.out_byte  = b;
    r.line_done = done;
    expected_bytes.push_back(r);
  endfunction

  // Work out the output run for the line that just ended.
  function automatic void predict_line_output();
    int i;
    int fi;
    int first;
    if (!line_passes_filter()) return;
    if (field_reg == 8'd0) begin
      for (i = 0; i < kept_len; i++) owe_byte(line_buf[i], 1'b0);
    end else begin
      i  = 0;
      fi = 0;
      while (i < kept_len) begin
        while (i < kept_len && is_field_sep(line_buf[i])) i++;
        if (i >= kept_len) break;
        first = i;
        while (i < kept_len && !is_field_sep(line_buf[i])) i++;
        if (fi == int'(field_reg) - 1) begin
          for (int k = first; k < i; k++) owe_byte(line_buf[k], 1'b0);
          break;
        end
        fi++;
      end
    end
    owe_byte(lfs_pkg::NL_BYTE, 1'b1);
  endfunction

  function automatic void clear_line();
    raw_len      = 0;
    kept_len     = 0;
    zero_in_line = 1'b0;
  endfunction

  // Update the line state for one accepted input request.
  function automatic void predict_step(lfs_pkg::in_req_t req);
    if (req.end_of_stream) begin
      if (raw_len > 0) predict_line_output();
      clear_line();
    end else if (req.data_byte == lfs_pkg::NL_BYTE) begin
      predict_line_output();
      clear_line();
    end else if (raw_len < LINE_MAX - 1) begin
      line_buf[raw_len] = req.data_byte;
      raw_len++;
      if (!zero_in_line) begin
        if (req.data_byte == 8'd0) zero_in_line = 1'b1;
        else kept_len++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall, long hold-off and result check
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected none, got %0d (line_done %0b)",
               out_req_o.out_byte, out_req_o.line_done);
        mismatch_count++;
      end else begin
        if (expected_bytes[0].out_byte !== out_req_o.out_byte) begin
          $error("out_byte: expected %0d, got %0d",
                 expected_bytes[0].out_byte, out_req_o.out_byte);
          mismatch_count++;
        end
        if (expected_bytes[0].line_done !== out_req_o.line_done) begin
          $error("line_done: expected %0b, got %0b",
                 expected_bytes[0].line_done, out_req_o.line_done);
          mismatch_count++;
        end
        void'(expected_bytes.pop_front());
      end
    end
    out_stall <= (hold_cycles > 0) || ($urandom_range(99) < rcv_stall_pct);
    if (hold_cycles > 0) hold_cycles--;
  end

  // ---------------------------------------------------------------------------
  // Input side and configuration
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the core takes it. The valid stays
  // high afterwards, so the caller sends again or lowers it in the same step.
  task automatic send_item(input lfs_pkg::in_req_t req);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_step(req);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    lfs_pkg::in_req_t req;
    req.data_byte     = b;
    req.end_of_stream = 1'b0;
    send_item(req);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // The data byte of an end-of-stream request is ignored, so it is random.
  task automatic send_eos();
    lfs_pkg::in_req_t req;
    req.data_byte     = 8'($urandom_range(255));
    req.end_of_stream = 1'b1;
    send_item(req);
  endtask

  // Stop offering, wait for every owed byte, then let a filtered line finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lfs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lfs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    case (idx)
      lfs_pkg::CFG_SEPARATOR:      sep_reg    = val[7:0];
      lfs_pkg::CFG_FIELD_NUMBER:   field_reg  = val[7:0];
      lfs_pkg::CFG_PATTERN_LENGTH: plen_reg   = val[4:0];
      lfs_pkg::CFG_PATTERN_LOW:    pat_lo_reg = val;
      lfs_pkg::CFG_PATTERN_HIGH:   pat_hi_reg = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: whole lines, empty lines and both kinds of stream end.
  task automatic test_whole_line();
    send_text("hi there\n");
    send_text("\n");
    send_eos();
    send_text("x");
    send_eos();
    wait_idle();
  endtask

  // Field selection with custom, tab-only and top-code separators.
  task automatic test_field_split();
    write_reg(lfs_pkg::CFG_SEPARATOR, 64'(","));
    write_reg(lfs_pkg::CFG_FIELD_NUMBER, 64'd2);
    send_text(",,a\t,b,c\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_FIELD_NUMBER, 64'd255);
    send_text("p,q\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_SEPARATOR, 64'd0);
    write_reg(lfs_pkg::CFG_FIELD_NUMBER, 64'd2);
    send_text("a,b\tc d\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_SEPARATOR, 64'hFF);
    write_reg(lfs_pkg::CFG_FIELD_NUMBER, 64'd1);
    send_byte(8'hFF);
    send_text("z");
    send_byte(8'hFF);
    send_text("\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_SEPARATOR, 64'(lfs_pkg::SEPARATOR_RST));
    write_reg(lfs_pkg::CFG_FIELD_NUMBER, 64'd0);
  endtask

  // A zero ends the kept text; an all-zero partial line flushes as empty;
  // bytes past the line limit are dropped, a zero among them too.
  task automatic test_zero_and_long();
    send_text("ab");
    send_byte(8'd0);
    send_text("cd\n");
    send_byte(8'd0);
    send_byte(8'd0);
    send_eos();
    for (int i = 0; i < 70; i++) send_byte((i == 66) ? 8'd0 : 8'(8'h41 + i % 26));
    send_text("\n");
    wait_idle();
  endtask

  // Substring filter: hit, miss, pattern longer than the line, an oversized
  // length, zeros inside the pattern and a write to an unused index.
  task automatic test_pattern_filter();
    write_reg(lfs_pkg::CFG_PATTERN_LOW, 64'h6261);          // "ab"
    write_reg(lfs_pkg::CFG_PATTERN_LENGTH, 64'd2);
    send_text("xaby\n");
    send_text("xba\n");
    send_text("a\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_PATTERN_LOW, 64'h3736353433323130);  // "01234567"
    write_reg(lfs_pkg::CFG_PATTERN_HIGH, 64'h4645444342413938); // "89ABCDEF"
    write_reg(lfs_pkg::CFG_PATTERN_LENGTH, 64'd31);
    send_text("-0123456789ABCDEF-\n");
    send_text("0123456789ABCDE\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_PATTERN_LOW, 64'h6200);          // first byte zero
    send_text("zz\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_PATTERN_LOW, 64'h71);            // "q" then zero
    write_reg(lfs_pkg::CFG_PATTERN_LENGTH, 64'd5);
    write_reg(CFG_UNUSED_INDEX, '1);
    send_text("aqa\n");
    send_text("aa\n");
    wait_idle();
    write_reg(lfs_pkg::CFG_PATTERN_HIGH, '1);
    write_reg(lfs_pkg::CFG_PATTERN_LENGTH, 64'd0);
  endtask

  // The receiver holds off while the sender keeps offering, so the core
  // sits in its output pass and pushes back on its input.
  task automatic test_output_backpressure();
    hold_cycles = 300;
    for (int n = 0; n < 3; n++) begin
      for (int i = 0; i < 20; i++) send_byte(8'(8'h61 + (i + n) % 26));
      send_text("\n");
    end
    wait_idle();
  endtask

  function automatic logic [7:0] alpha_byte();
    return 8'(8'h61 + $urandom_range(2));
  endfunction

  // Mostly letters and separators so that fields and matches are common.
  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return alpha_byte();
    if (r < 58) return (sep_reg == 8'd0) ? lfs_pkg::TAB_BYTE : sep_reg;
    if (r < 68) return lfs_pkg::TAB_BYTE;
    if (r < 73) return 8'd0;
    if (r < 80) return 8'($urandom_range(255));
    return pattern_byte($urandom_range(PATTERN_MAX - 1));
  endfunction

  // Random settings, then random lines with the pattern often planted.
  task automatic test_random_streams();
    logic [63:0] lo;
    logic [63:0] hi;
    int          r;
    int          len;
    int          plant;
    int          stop_at;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin snd_idle_pct = 11; rcv_stall_pct = 60; end
        1: begin snd_idle_pct = 60; rcv_stall_pct = 11; end
        default: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      for (int phase = 0; phase < 2; phase++) begin
        r = $urandom_range(4);
        write_reg(lfs_pkg::CFG_SEPARATOR, {$urandom, 24'($urandom),
                                  (r == 0) ? 8'd32 : (r == 1) ? 8'd0 :
                                  (r == 2) ? 8'hFF : (r == 3) ? 8'(",") :
                                  8'($urandom_range(255))});
        r = $urandom_range(5);
        write_reg(lfs_pkg::CFG_FIELD_NUMBER,
                  64'((r < 2) ? 0 : (r < 4) ? $urandom_range(1, 3) :
                      (r == 4) ? 255 : $urandom_range(255)));
        r = $urandom_range(9);
        write_reg(lfs_pkg::CFG_PATTERN_LENGTH,
                  64'((r < 3) ? 0 : (r < 8) ? $urandom_range(1, 4) :
                      (r == 8) ? $urandom_range(5, 16) : $urandom_range(17, 31)));
        for (int k = 0; k < 8; k++) begin
          lo[8*k +: 8] = ($urandom_range(15) == 0) ? 8'd0 : alpha_byte();
          hi[8*k +: 8] = ($urandom_range(15) == 0) ? 8'd0 : alpha_byte();
        end
        if ($urandom_range(5) == 0) lo = {$urandom, $urandom};
        if ($urandom_range(5) == 0) hi = {$urandom, $urandom};
        write_reg(lfs_pkg::CFG_PATTERN_LOW, lo);
        write_reg(lfs_pkg::CFG_PATTERN_HIGH, hi);

        stop_at = bytes_sent + 8;
        while (bytes_sent < stop_at) begin
          len   = ($urandom_range(9) == 0) ? $urandom_range(50, 75) : $urandom_range(12);
          plant = ($urandom_range(2) == 0) ? $urandom_range(len) : -1;
          for (int j = 0; j <= len; j++) begin
            if (j == plant) begin
              for (int k = 0; k < plen_reg && k < PATTERN_MAX; k++) send_byte(pattern_byte(k));
            end
            if (j < len) send_byte(stream_byte());
          end
          r = $urandom_range(19);
          if (r < 17) send_text("\n");
          else if (r < 19) send_eos();
        end
        send_text("\n");
        wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= lfs_pkg::CFG_SEPARATOR;
    cfg_data  <= '0;
    sep_reg        = lfs_pkg::SEPARATOR_RST;
    field_reg      = 8'd0;
    plen_reg       = 5'd0;
    pat_lo_reg     = '0;
    pat_hi_reg     = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    hold_cycles    = 0;
    snd_idle_pct   = 11;
    rcv_stall_pct  = 60;
    clear_line();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_whole_line();
    test_field_split();
    test_zero_and_long();
    test_pattern_filter();
    test_output_backpressure();
    test_random_streams();

    if (mismatch_count == 0) begin
      $display("line_field_selector_with_filter_core_test OK");
    end else begin
      $display("line_field_selector_with_filter_core_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lfs_pkg.sv
rtl/core/lfs_match_cell.sv
rtl/core/lfs_field_sel.sv
rtl/core/line_field_selector_with_filter_core.sv
bench/line_field_selector_with_filter_core_test.sv
